### hdl/ffca_pkg.sv
// Shared types and constants of the first-fit coalescing allocator.
// Holds the descriptor table sizes, operation and status codes, and the
// command and status structs between the controller and the datapath.
package ffca_pkg;

    localparam int NUM_DESC  = 32;
    localparam int POOL_BITS = 24;
    localparam int GRAIN     = 32;
    localparam int ENT_W     = $clog2(NUM_DESC);
    localparam int IDX_W     = ENT_W + 1;
    localparam int SZ_W      = POOL_BITS + 1;
    localparam int HND_W     = 5;
    localparam int STEP_W    = $clog2(NUM_DESC + 1);
    localparam int RESET_POOL = 1048576;

    localparam logic [IDX_W-1:0] NIL = IDX_W'(NUM_DESC);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_AREA   = 2'd1,
        ST_NO_SPARE  = 2'd2,
        ST_BAD_HNDL  = 2'd3
    } status_t;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        U_NOP,
        U_LOAD,
        U_INIT_ROW,
        U_HIT,
        U_STEP,
        U_POP_RD,
        U_POP_WR,
        U_WR_D,
        U_LINK_PP,
        U_WR_P,
        U_LINK_PN,
        U_PUSH_ROW,
        U_PUSH_LINK,
        U_F_RD_H,
        U_F_PREV,
        U_F_LINK_BEFORE,
        U_F_NEXT,
        U_F_LINK_AFTER,
        U_F_WR_H,
        U_ERR_NOSPARE,
        U_ERR_NOFIT,
        U_ERR_HANDLE,
        U_EMIT
    } uop_t;

    // Which descriptor the table read port looks at.
    typedef enum logic [2:0] {
        RD_P,
        RD_TAIL,
        RD_H,
        RD_HPREV,
        RD_HNEXT
    } rd_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_BRANCH,
        S_INIT,
        S_WALK,
        S_POP_RD,
        S_POP_WR,
        S_WR_D,
        S_LINK_PP,
        S_WR_P,
        S_LINK_PN,
        S_PUSH_ROW,
        S_PUSH_LINK,
        S_F_PREV,
        S_F_LINK_BEFORE,
        S_F_NEXT,
        S_F_LINK_AFTER,
        S_F_WR_H,
        S_DONE
    } state_t;

    typedef struct packed {
        uop_t    uop;
        rd_sel_t rd_sel;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic alloc_ok;
        logic rd_ok;
        logic rd_free;
        logic rd_alloc;
        logic rd_fit;
        logic steps_max;
        logic exact;
        logic init_last;
    } sts_t;

    function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
        return idx < NIL;
    endfunction

endpackage

### hdl/ffca_req_if.sv
// Request channel of the allocator: valid, ready and one request item.
// Depends on ffca_pkg for field widths.
interface ffca_req_if
    import ffca_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [1:0]           op;
    logic [POOL_BITS-1:0] request_size;
    logic [HND_W-1:0]     free_handle;

    modport source (output valid, op, request_size, free_handle, input ready);
    modport sink (input valid, op, request_size, free_handle, output ready);
endinterface

### hdl/ffca_rsp_if.sv
// Response channel of the allocator: valid, ready and one result item.
// Depends on ffca_pkg for field widths.
interface ffca_rsp_if
    import ffca_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [HND_W-1:0]     handle;
    logic [POOL_BITS-1:0] offset;
    logic [POOL_BITS-1:0] granted_size;

    modport source (output valid, status, handle, offset, granted_size, input ready);
    modport sink (input valid, status, handle, offset, granted_size, output ready);
endinterface

### hdl/ffca_ctrl.sv
// Controller of the allocator: sequences table operations for each item.
// Depends on ffca_pkg; drives ffca_dp through cmd_t and reads sts_t.
module ffca_ctrl
    import ffca_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    output logic rsp_valid,
    input  logic rsp_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   out_valid_reg, out_valid_next;

    // State, return point and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        cmd.uop        = U_NOP;
        cmd.rd_sel     = RD_P;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.uop    = U_LOAD;
                    state_next = S_BRANCH;
                end
            end
            S_BRANCH:
            begin
                cmd.rd_sel = RD_H;
                case (sts.op)
                    OP_INIT:  state_next = S_INIT;
                    OP_ALLOC:
                    begin
                        if (sts.alloc_ok)
                        begin
                            state_next = S_WALK;
                        end
                        else
                        begin
                            cmd.uop    = U_ERR_NOSPARE;
                            state_next = S_DONE;
                        end
                    end
                    OP_FREE:
                    begin
                        if (sts.rd_ok && sts.rd_alloc)
                        begin
                            cmd.uop    = U_F_RD_H;
                            state_next = S_F_PREV;
                        end
                        else
                        begin
                            cmd.uop    = U_ERR_HANDLE;
                            state_next = S_DONE;
                        end
                    end
                    default:  state_next = S_DONE;
                endcase
            end
            S_INIT:
            begin
                cmd.uop = U_INIT_ROW;
                if (sts.init_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_WALK:
            begin
                cmd.rd_sel = RD_P;
                if (!sts.rd_ok || sts.steps_max)
                begin
                    cmd.uop    = U_ERR_NOFIT;
                    state_next = S_DONE;
                end
                else if (sts.rd_free && sts.rd_fit)
                begin
                    cmd.uop    = U_HIT;
                    state_next = S_POP_RD;
                end
                else
                begin
                    cmd.uop = U_STEP;
                end
            end
            S_POP_RD:
            begin
                cmd.rd_sel = RD_TAIL;
                cmd.uop    = U_POP_RD;
                state_next = S_POP_WR;
            end
            S_POP_WR:
            begin
                cmd.uop    = U_POP_WR;
                state_next = S_WR_D;
            end
            S_WR_D:
            begin
                cmd.uop    = U_WR_D;
                state_next = S_LINK_PP;
            end
            S_LINK_PP:
            begin
                cmd.uop    = U_LINK_PP;
                state_next = sts.exact ? S_LINK_PN : S_WR_P;
            end
            S_WR_P:
            begin
                cmd.uop    = U_WR_P;
                state_next = S_DONE;
            end
            S_LINK_PN:
            begin
                cmd.uop    = U_LINK_PN;
                ret_next   = S_DONE;
                state_next = S_PUSH_ROW;
            end
            S_PUSH_ROW:
            begin
                cmd.uop    = U_PUSH_ROW;
                state_next = S_PUSH_LINK;
            end
            S_PUSH_LINK:
            begin
                cmd.uop    = U_PUSH_LINK;
                state_next = ret_reg;
            end
            S_F_PREV:
            begin
                cmd.rd_sel = RD_HPREV;
                if (sts.rd_ok && sts.rd_free)
                begin
                    cmd.uop    = U_F_PREV;
                    state_next = S_F_LINK_BEFORE;
                end
                else
                begin
                    state_next = S_F_NEXT;
                end
            end
            S_F_LINK_BEFORE:
            begin
                cmd.uop    = U_F_LINK_BEFORE;
                ret_next   = S_F_NEXT;
                state_next = S_PUSH_ROW;
            end
            S_F_NEXT:
            begin
                cmd.rd_sel = RD_HNEXT;
                if (sts.rd_ok && sts.rd_free)
                begin
                    cmd.uop    = U_F_NEXT;
                    state_next = S_F_LINK_AFTER;
                end
                else
                begin
                    state_next = S_F_WR_H;
                end
            end
            S_F_LINK_AFTER:
            begin
                cmd.uop    = U_F_LINK_AFTER;
                ret_next   = S_F_WR_H;
                state_next = S_PUSH_ROW;
            end
            S_F_WR_H:
            begin
                cmd.uop    = U_F_WR_H;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.uop        = U_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

### hdl/ffca_dp.sv
// Datapath of the allocator: descriptor table, list pointers and scratch.
// Depends on ffca_pkg; carries out one cmd_t operation each cycle.
module ffca_dp
    import ffca_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic                 cfg_wr_en,
    input  logic [POOL_BITS-1:0] cfg_wr_data,
    input  logic [1:0]           in_op,
    input  logic [POOL_BITS-1:0] in_request_size,
    input  logic [HND_W-1:0]     in_free_handle,
    output logic [1:0]           out_status,
    output logic [HND_W-1:0]     out_handle,
    output logic [POOL_BITS-1:0] out_offset,
    output logic [POOL_BITS-1:0] out_granted_size
);

    // Descriptor table: one read and one write address per cycle.
    logic [POOL_BITS-1:0] start_mem [NUM_DESC];
    logic [POOL_BITS-1:0] size_mem  [NUM_DESC];
    logic [IDX_W-1:0]     prev_mem  [NUM_DESC];
    logic [IDX_W-1:0]     next_mem  [NUM_DESC];
    logic [NUM_DESC-1:0]  alloc_reg;

    logic [POOL_BITS-1:0] pool_size_reg;
    logic                 ready_reg;
    logic [IDX_W-1:0]     head_reg, tail_reg;
    op_t                  op_reg;
    logic [SZ_W-1:0]      sz_reg;
    logic [ENT_W-1:0]     cnt_reg;
    logic [IDX_W-1:0]     p_reg, pp_reg, pn_reg, tnew_reg, old_tail_reg;
    logic [STEP_W-1:0]    steps_reg;
    logic [POOL_BITS-1:0] pstart_reg, psize_reg;
    logic [ENT_W-1:0]     d_reg, push_reg;
    logic [IDX_W-1:0]     h_reg, hprev_reg, hnext_reg;
    logic [POOL_BITS-1:0] hstart_reg, hsize_reg;
    logic [1:0]           res_status_reg;
    logic [HND_W-1:0]     res_handle_reg;
    logic [POOL_BITS-1:0] res_offset_reg, res_size_reg;
    logic [1:0]           out_status_reg;
    logic [HND_W-1:0]     out_handle_reg;
    logic [POOL_BITS-1:0] out_offset_reg, out_size_reg;

    logic [IDX_W-1:0]     rd_idx;
    logic [ENT_W-1:0]     rd_ent;
    logic [POOL_BITS-1:0] rd_start, rd_size;
    logic [IDX_W-1:0]     rd_prev, rd_next;
    logic                 rd_alloc;

    logic                 we_start, we_size, we_state, we_prev, we_next;
    logic [ENT_W-1:0]     wr_ent;
    logic [POOL_BITS-1:0] wd_start, wd_size;
    logic                 wd_state;
    logic [IDX_W-1:0]     wd_prev, wd_next;
    logic [ENT_W-1:0]     cnt_ent_last;

    assign cnt_ent_last = ENT_W'(NUM_DESC - 1);

    // Read port address.
    always_comb
    begin
        case (cmd.rd_sel)
            RD_P:     rd_idx = p_reg;
            RD_TAIL:  rd_idx = tail_reg;
            RD_H:     rd_idx = h_reg;
            RD_HPREV: rd_idx = hprev_reg;
            RD_HNEXT: rd_idx = hnext_reg;
            default:  rd_idx = p_reg;
        endcase
    end

    assign rd_ent   = rd_idx[ENT_W-1:0];
    assign rd_start = start_mem[rd_ent];
    assign rd_size  = size_mem[rd_ent];
    assign rd_prev  = prev_mem[rd_ent];
    assign rd_next  = next_mem[rd_ent];
    assign rd_alloc = alloc_reg[rd_ent];

    // Status towards the controller.
    always_comb
    begin
        sts.op        = op_reg;
        sts.alloc_ok  = ready_reg && idx_ok(tail_reg);
        sts.rd_ok     = idx_ok(rd_idx);
        sts.rd_free   = !rd_alloc;
        sts.rd_alloc  = rd_alloc;
        sts.rd_fit    = {1'b0, rd_size} >= sz_reg;
        sts.steps_max = steps_reg == STEP_W'(NUM_DESC);
        sts.exact     = {1'b0, psize_reg} == sz_reg;
        sts.init_last = cnt_reg == cnt_ent_last;
    end

    // Table write port decode.
    always_comb
    begin
        we_start = 1'b0;
        we_size  = 1'b0;
        we_state = 1'b0;
        we_prev  = 1'b0;
        we_next  = 1'b0;
        wr_ent   = d_reg;
        wd_start = '0;
        wd_size  = '0;
        wd_state = 1'b0;
        wd_prev  = NIL;
        wd_next  = NIL;
        case (cmd.uop)
            U_INIT_ROW:
            begin
                we_start = 1'b1;
                we_size  = 1'b1;
                we_state = 1'b1;
                we_prev  = 1'b1;
                we_next  = 1'b1;
                wr_ent   = cnt_reg;
                // The last row holds the whole pool and heads the list.
                if (cnt_reg == cnt_ent_last)
                begin
                    wd_size = pool_size_reg;
                end
                else
                begin
                    if (cnt_reg != '0)
                    begin
                        wd_prev = {1'b0, cnt_reg} - IDX_W'(1);
                    end
                    if (cnt_reg != ENT_W'(NUM_DESC - 2))
                    begin
                        wd_next = {1'b0, cnt_reg} + IDX_W'(1);
                    end
                end
            end
            U_POP_WR:
            begin
                we_next = idx_ok(tnew_reg);
                wr_ent  = tnew_reg[ENT_W-1:0];
            end
            U_WR_D:
            begin
                we_start = 1'b1;
                we_size  = 1'b1;
                we_state = 1'b1;
                we_prev  = 1'b1;
                we_next  = 1'b1;
                wr_ent   = d_reg;
                wd_start = pstart_reg;
                wd_size  = sz_reg[POOL_BITS-1:0];
                wd_state = 1'b1;
                wd_prev  = pp_reg;
                wd_next  = ({1'b0, psize_reg} == sz_reg) ? pn_reg : p_reg;
            end
            U_LINK_PP:
            begin
                we_next = idx_ok(pp_reg);
                wr_ent  = pp_reg[ENT_W-1:0];
                wd_next = {1'b0, d_reg};
            end
            U_WR_P:
            begin
                we_start = 1'b1;
                we_size  = 1'b1;
                we_prev  = 1'b1;
                wr_ent   = p_reg[ENT_W-1:0];
                wd_start = pstart_reg + sz_reg[POOL_BITS-1:0];
                wd_size  = psize_reg - sz_reg[POOL_BITS-1:0];
                wd_prev  = {1'b0, d_reg};
            end
            U_LINK_PN:
            begin
                we_prev = idx_ok(pn_reg);
                wr_ent  = pn_reg[ENT_W-1:0];
                wd_prev = {1'b0, d_reg};
            end
            U_PUSH_ROW:
            begin
                we_prev = 1'b1;
                we_next = 1'b1;
                wr_ent  = push_reg;
                wd_prev = tail_reg;
            end
            U_PUSH_LINK:
            begin
                we_next = idx_ok(old_tail_reg);
                wr_ent  = old_tail_reg[ENT_W-1:0];
                wd_next = {1'b0, push_reg};
            end
            U_F_LINK_BEFORE:
            begin
                we_next = idx_ok(hprev_reg);
                wr_ent  = hprev_reg[ENT_W-1:0];
                wd_next = h_reg;
            end
            U_F_LINK_AFTER:
            begin
                we_prev = idx_ok(hnext_reg);
                wr_ent  = hnext_reg[ENT_W-1:0];
                wd_prev = h_reg;
            end
            U_F_WR_H:
            begin
                we_start = 1'b1;
                we_size  = 1'b1;
                we_state = 1'b1;
                we_prev  = 1'b1;
                we_next  = 1'b1;
                wr_ent   = h_reg[ENT_W-1:0];
                wd_start = hstart_reg;
                wd_size  = hsize_reg;
                wd_prev  = hprev_reg;
                wd_next  = hnext_reg;
            end
            default:
            begin
                we_start = 1'b0;
            end
        endcase
    end

    // Table contents without reset.
    always_ff @(posedge clk)
    begin
        if (we_start)
        begin
            start_mem[wr_ent] <= wd_start;
        end
        if (we_size)
        begin
            size_mem[wr_ent] <= wd_size;
        end
        if (we_prev)
        begin
            prev_mem[wr_ent] <= wd_prev;
        end
        if (we_next)
        begin
            next_mem[wr_ent] <= wd_next;
        end
    end

    // Allocated bits clear to free at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_reg <= '0;
        end
        else if (we_state)
        begin
            alloc_reg[wr_ent] <= wd_state;
        end
    end

    // Control registers: pool size, list ends and readiness.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg <= POOL_BITS'(RESET_POOL);
            ready_reg     <= 1'b0;
            head_reg      <= NIL;
            tail_reg      <= NIL;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pool_size_reg <= cfg_wr_data;
            end
            case (cmd.uop)
                U_LOAD:
                begin
                    cnt_reg <= '0;
                end
                U_INIT_ROW:
                begin
                    cnt_reg <= cnt_reg + ENT_W'(1);
                    if (cnt_reg == cnt_ent_last)
                    begin
                        head_reg  <= IDX_W'(NUM_DESC - 1);
                        tail_reg  <= IDX_W'(NUM_DESC - 2);
                        ready_reg <= 1'b1;
                    end
                end
                U_POP_WR:
                begin
                    tail_reg <= tnew_reg;
                end
                U_LINK_PP:
                begin
                    if (!idx_ok(pp_reg))
                    begin
                        head_reg <= {1'b0, d_reg};
                    end
                end
                U_PUSH_ROW:
                begin
                    tail_reg <= {1'b0, push_reg};
                end
                U_F_LINK_BEFORE:
                begin
                    if (!idx_ok(hprev_reg))
                    begin
                        head_reg <= h_reg;
                    end
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    // Scratch and result registers.
    always_ff @(posedge clk)
    begin
        case (cmd.uop)
            U_LOAD:
            begin
                op_reg         <= op_t'(in_op);
                sz_reg         <= ({1'b0, in_request_size} | SZ_W'(GRAIN - 1)) + SZ_W'(1);
                h_reg          <= IDX_W'(in_free_handle);
                p_reg          <= head_reg;
                steps_reg      <= '0;
                res_status_reg <= ST_OK;
                res_handle_reg <= '0;
                res_offset_reg <= '0;
                res_size_reg   <= '0;
            end
            U_HIT:
            begin
                pstart_reg <= rd_start;
                psize_reg  <= rd_size;
                pp_reg     <= rd_prev;
                pn_reg     <= rd_next;
            end
            U_STEP:
            begin
                p_reg     <= rd_next;
                steps_reg <= steps_reg + STEP_W'(1);
            end
            U_POP_RD:
            begin
                d_reg    <= tail_reg[ENT_W-1:0];
                tnew_reg <= rd_prev;
            end
            U_WR_D:
            begin
                res_handle_reg <= HND_W'(d_reg);
                res_offset_reg <= pstart_reg;
                res_size_reg   <= sz_reg[POOL_BITS-1:0];
            end
            U_LINK_PN:
            begin
                push_reg <= p_reg[ENT_W-1:0];
            end
            U_PUSH_ROW:
            begin
                old_tail_reg <= tail_reg;
            end
            U_F_RD_H:
            begin
                hstart_reg <= rd_start;
                hsize_reg  <= rd_size;
                hprev_reg  <= rd_prev;
                hnext_reg  <= rd_next;
            end
            U_F_PREV:
            begin
                hsize_reg  <= hsize_reg + rd_size;
                hstart_reg <= hstart_reg - rd_size;
                hprev_reg  <= rd_prev;
                push_reg   <= hprev_reg[ENT_W-1:0];
            end
            U_F_NEXT:
            begin
                hsize_reg <= hsize_reg + rd_size;
                hnext_reg <= rd_next;
                push_reg  <= hnext_reg[ENT_W-1:0];
            end
            U_F_WR_H:
            begin
                res_handle_reg <= h_reg[HND_W-1:0];
            end
            U_ERR_NOSPARE:
            begin
                res_status_reg <= ST_NO_SPARE;
            end
            U_ERR_NOFIT:
            begin
                res_status_reg <= ST_NO_AREA;
            end
            U_ERR_HANDLE:
            begin
                res_status_reg <= ST_BAD_HNDL;
            end
            U_EMIT:
            begin
                out_status_reg <= res_status_reg;
                out_handle_reg <= res_handle_reg;
                out_offset_reg <= res_offset_reg;
                out_size_reg   <= res_size_reg;
            end
            default:
            begin
                op_reg <= op_reg;
            end
        endcase
    end

    assign out_status       = out_status_reg;
    assign out_handle       = out_handle_reg;
    assign out_offset       = out_offset_reg;
    assign out_granted_size = out_size_reg;

endmodule

### hdl/first_fit_coalescing_allocator.sv
// Top level of the first-fit coalescing allocator.
// Depends on ffca_pkg, ffca_req_if, ffca_rsp_if, ffca_ctrl and ffca_dp.
//
//   Channel   Direction  Carries
//   req_ch    in         op, request_size, free_handle
//   rsp_ch    out        status, handle, offset, granted_size
//   cfg_wr_*  in         pool_size register write
//
// One item at a time. Alloc walks the descriptor list, examining up to 32
// descriptors, and then relinks; free refuses a bad handle or merges the
// freed block with its free neighbours; init writes every descriptor row.
// The walk over the descriptor table, one entry per cycle, sets the alloc time.
// Reset leaves the pool uninitialised; alloc reports no spare descriptor until init.
// A finished item waits in the output register while the next item is taken.
module first_fit_coalescing_allocator
    import ffca_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [POOL_BITS-1:0] cfg_wr_data,
    ffca_req_if.sink             req_ch,
    ffca_rsp_if.source           rsp_ch
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    ffca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_ch.valid),
        .req_ready (req_ch.ready),
        .rsp_valid (rsp_ch.valid),
        .rsp_ready (rsp_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Descriptor table and arithmetic.
    ffca_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_op            (req_ch.op),
        .in_request_size  (req_ch.request_size),
        .in_free_handle   (req_ch.free_handle),
        .out_status       (rsp_ch.status),
        .out_handle       (rsp_ch.handle),
        .out_offset       (rsp_ch.offset),
        .out_granted_size (rsp_ch.granted_size)
    );

endmodule

### test/tb_top.sv
// Self-checking testbench of the first-fit coalescing allocator.
// Depends on ffca_pkg, ffca_req_if, ffca_rsp_if and first_fit_coalescing_allocator.
// A behavioural predictor mirrors the descriptor table and checks every response item.
module tb_top;
    import ffca_pkg::*;

    typedef struct {
        logic [1:0]           status;
        logic [HND_W-1:0]     handle;
        logic [POOL_BITS-1:0] offset;
        logic [POOL_BITS-1:0] granted_size;
    } rsp_item_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [POOL_BITS-1:0] cfg_wr_data;

    ffca_req_if req_ch ();
    ffca_rsp_if rsp_ch ();

    first_fit_coalescing_allocator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_ch      (req_ch.sink),
        .rsp_ch      (rsp_ch.source)
    );

    // Shadow copy of the descriptor table and configuration.
    logic [31:0] shadow_pool;
    logic [31:0] desc_start [NUM_DESC];
    logic [31:0] desc_size [NUM_DESC];
    logic        desc_busy [NUM_DESC];
    int          desc_prev [NUM_DESC];
    int          desc_next [NUM_DESC];
    int          head_desc;
    int          spare_end;
    logic        pool_built;

    rsp_item_t expected_rsp [$];
    int        error_count;
    int        rsp_seen;
    int        idle_pct;
    logic      stretch_no_idle;

    // Clock with a period of two time units.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic bit valid_desc(input int d);
        return d >= 0 && d < NUM_DESC;
    endfunction

    function automatic void spare_add(input int d);
        desc_prev[d] = spare_end;
        desc_next[d] = NUM_DESC;
        if (valid_desc(spare_end))
            desc_next[spare_end] = d;
        spare_end = d;
    endfunction

    function automatic int spare_take();
        int d;
        d = spare_end;
        if (!valid_desc(d))
            return NUM_DESC;
        spare_end = desc_prev[d];
        if (valid_desc(spare_end))
            desc_next[spare_end] = NUM_DESC;
        desc_prev[d] = NUM_DESC;
        return d;
    endfunction

    function automatic void wipe_table();
        for (int i = 0; i < NUM_DESC; i++)
        begin
            desc_start[i] = 0;
            desc_size[i] = 0;
            desc_busy[i] = 1'b0;
            desc_prev[i] = NUM_DESC;
            desc_next[i] = NUM_DESC;
        end
        head_desc = NUM_DESC;
        spare_end = NUM_DESC;
    endfunction

    // Works out the response item of one request and updates the shadow table.
    function automatic rsp_item_t allocator_response(input logic [1:0] op,
                                                     input logic [POOL_BITS-1:0] req_size,
                                                     input logic [HND_W-1:0] hnd);
        rsp_item_t r;
        logic [31:0] rounded;
        int p, pp, d, q, nb, steps;
        bit found;
        r = '{ST_OK, '0, '0, '0};
        if (op == OP_INIT)
        begin
            wipe_table();
            for (int i = 0; i < NUM_DESC; i++)
                spare_add(i);
            head_desc = spare_take();
            desc_busy[head_desc] = 1'b0;
            desc_size[head_desc] = shadow_pool & 32'hFFFFFF;
            desc_start[head_desc] = 0;
            pool_built = 1'b1;
        end
        else if (op == OP_ALLOC)
        begin
            rounded = req_size + (GRAIN - (req_size % GRAIN));
            if (!pool_built || !valid_desc(spare_end))
                r.status = ST_NO_SPARE;
            else
            begin
                p = head_desc;
                steps = 0;
                found = 0;
                while (valid_desc(p) && steps < NUM_DESC)
                begin
                    if (!desc_busy[p] && desc_size[p] >= rounded)
                    begin
                        found = 1;
                        break;
                    end
                    p = desc_next[p];
                    steps++;
                end
                if (!found)
                    r.status = ST_NO_AREA;
                else
                begin
                    d = spare_take();
                    pp = desc_prev[p];
                    desc_size[d] = rounded;
                    desc_busy[d] = 1'b1;
                    desc_start[d] = desc_start[p];
                    desc_next[d] = p;
                    desc_prev[d] = pp;
                    if (valid_desc(pp))
                        desc_next[pp] = d;
                    else
                        head_desc = d;
                    desc_size[p] = desc_size[p] - rounded;
                    if (desc_size[p] == 0)
                    begin
                        nb = desc_next[p];
                        if (valid_desc(nb))
                            desc_prev[nb] = d;
                        desc_next[d] = nb;
                        spare_add(p);
                    end
                    else
                    begin
                        desc_start[p] = (desc_start[p] + rounded) & 32'hFFFFFF;
                        desc_prev[p] = d;
                    end
                    r.handle = d[HND_W-1:0];
                    r.offset = desc_start[d][POOL_BITS-1:0];
                    r.granted_size = rounded[POOL_BITS-1:0];
                end
            end
        end
        else if (op == OP_FREE)
        begin
            if (!desc_busy[hnd])
                r.status = ST_BAD_HNDL;
            else
            begin
                desc_busy[hnd] = 1'b0;
                q = desc_prev[hnd];
                if (valid_desc(q) && !desc_busy[q])
                begin
                    nb = desc_prev[q];
                    desc_size[hnd] = (desc_size[hnd] + desc_size[q]) & 32'hFFFFFF;
                    desc_start[hnd] = (desc_start[hnd] - desc_size[q]) & 32'hFFFFFF;
                    spare_add(q);
                    desc_prev[hnd] = nb;
                    if (valid_desc(nb))
                        desc_next[nb] = hnd;
                    else
                        head_desc = hnd;
                end
                q = desc_next[hnd];
                if (valid_desc(q) && !desc_busy[q])
                begin
                    nb = desc_next[q];
                    desc_size[hnd] = (desc_size[hnd] + desc_size[q]) & 32'hFFFFFF;
                    spare_add(q);
                    desc_next[hnd] = nb;
                    if (valid_desc(nb))
                        desc_prev[nb] = hnd;
                end
                r.handle = hnd;
            end
        end
        return r;
    endfunction

    function automatic bit idle_now();
        return !stretch_no_idle && ($urandom_range(99) < idle_pct);
    endfunction

    // Sends one request item and records its expected response.
    // Valid stays high after an accept; the next call replaces the item or drops valid, and the drain drops it.
    task automatic send_request(input logic [1:0] op, input logic [POOL_BITS-1:0] req_size,
                                input logic [HND_W-1:0] hnd);
        while (idle_now())
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op <= op;
        req_ch.request_size <= req_size;
        req_ch.free_handle <= hnd;
        do
            @(posedge clk);
        while (!req_ch.ready);
        expected_rsp.push_back(allocator_response(op, req_size, hnd));
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (60)
            @(posedge clk);
    endtask

    task automatic write_pool_size(input logic [POOL_BITS-1:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        shadow_pool = value;
    endtask

    // Receiver: random stalls, and each response compared with the oldest expectation.
    always @(posedge clk)
    begin
        rsp_item_t e;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_seen++;
                if (expected_rsp.size() == 0)
                begin
                    $error("response item with no request outstanding");
                    error_count++;
                end
                else
                begin
                    e = expected_rsp.pop_front();
                    if (rsp_ch.status !== e.status)
                    begin
                        $error("status expected %0d actual %0d", e.status, rsp_ch.status);
                        error_count++;
                    end
                    if (rsp_ch.handle !== e.handle)
                    begin
                        $error("handle expected %0d actual %0d", e.handle, rsp_ch.handle);
                        error_count++;
                    end
                    if (rsp_ch.offset !== e.offset)
                    begin
                        $error("offset expected %0d actual %0d", e.offset, rsp_ch.offset);
                        error_count++;
                    end
                    if (rsp_ch.granted_size !== e.granted_size)
                    begin
                        $error("granted_size expected %0d actual %0d", e.granted_size,
                               rsp_ch.granted_size);
                        error_count++;
                    end
                end
            end
            rsp_ch.ready <= !idle_now();
        end
    end

    // Directed checks of the corner cases named in the specification.
    task automatic test_directed();
        send_request(OP_ALLOC, 24'd5, '0);
        send_request(OP_FREE, '0, 5'd3);
        send_request(OP_NONE, 24'hFFFFFF, 5'h1F);
        send_request(OP_INIT, '0, '0);
        send_request(OP_ALLOC, 24'd1, '0);
        send_request(OP_ALLOC, 24'd32, '0);
        send_request(OP_ALLOC, 24'hFFFFFF, 5'h1F);
        send_request(OP_ALLOC, 24'hFFFFE0, '0);
        send_request(OP_FREE, '0, 5'd31);
        send_request(OP_FREE, '0, 5'd0);
        send_request(OP_FREE, '0, 5'd0);
        send_request(OP_FREE, '0, 5'd1);
        // Exhaust the spare list with small grants; the last requests find no spare descriptor.
        for (int i = 0; i < 33; i++)
            send_request(OP_ALLOC, 24'd20, '0);
        send_request(OP_INIT, '0, '0);
    endtask

    // Mostly allocations and frees of live handles; sometimes init or junk ops.
    task automatic test_random(input int count);
        int kind;
        logic [POOL_BITS-1:0] sz;
        logic [HND_W-1:0] h;
        for (int n = 0; n < count; n++)
        begin
            stretch_no_idle = (n % 400) >= 300;
            kind = $urandom_range(99);
            h = HND_W'($urandom());
            case ($urandom_range(9))
                0: sz = POOL_BITS'($urandom());
                1: sz = POOL_BITS'(32'hFFFFFF - $urandom_range(63));
                2: sz = POOL_BITS'($urandom_range(4096) * 32);
                default: sz = POOL_BITS'($urandom_range(1, 3000));
            endcase
            if (kind < 47)
                send_request(OP_ALLOC, sz, h);
            else if (kind < 94)
            begin
                // Prefer a handle that is currently allocated.
                for (int t = 0; t < 8 && !desc_busy[h]; t++)
                    h = HND_W'($urandom());
                send_request(OP_FREE, sz, h);
            end
            else if (kind < 97)
                send_request(OP_INIT, sz, h);
            else
                send_request(OP_NONE, sz, h);
            if (n == count / 2)
                wait_drained();
        end
        stretch_no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        req_ch.valid = 1'b0;
        req_ch.op = OP_NONE;
        req_ch.request_size = '0;
        req_ch.free_handle = '0;
        rsp_ch.ready = 1'b0;
        error_count = 0;
        rsp_seen = 0;
        idle_pct = 23;
        stretch_no_idle = 1'b0;
        shadow_pool = RESET_POOL;
        pool_built = 1'b0;
        wipe_table();
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        write_pool_size(24'd32);
        send_request(OP_INIT, '0, '0);
        test_random(150);
        write_pool_size(24'hFFFFE0);
        send_request(OP_INIT, '0, '0);
        test_random(400);
        write_pool_size(24'd1000);
        send_request(OP_INIT, '0, '0);
        test_random(400);
        write_pool_size(24'd0);
        send_request(OP_INIT, '0, '0);
        test_random(50);
        write_pool_size(24'hFFFFFF);
        send_request(OP_INIT, '0, '0);
        test_random(250);
        write_pool_size(24'd4096);
        send_request(OP_INIT, '0, '0);
        test_random(450);
        wait_drained();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Guard against a hang.
    initial
    begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
